### rtl/core/mvs_pkg.sv
// Shared types, sizes and step functions for the messenger voxel sampler.
// Used by the divider and square-root cells, the core and the checker.
package mvs_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned TAU_WIDTH   = 31;
  localparam int unsigned IDX_WIDTH   = 8;

  // One quotient bit per divider cell, one root bit per square-root cell.
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned SQRT_STEPS = 28;
  // Register stages from an accepted beat to its result strobe.
  localparam int unsigned LATENCY = 9 + DIV_STEPS + SQRT_STEPS;

  localparam logic [IDX_WIDTH-1:0] REG_MODE = 8'd0;
  localparam logic [IDX_WIDTH-1:0] REG_TAU  = 8'd1;

  typedef enum logic [1:0] {
    KIND_MEAN,
    KIND_MASK,
    KIND_MOCK,
    KIND_PLAIN
  } kind_e;

  // Per-voxel information that rides along the whole pipeline.
  typedef struct packed {
    kind_e              kind;
    logic               mean_neg;
    logic               draw_neg;
    logic [31:0]        draw_mag;
    logic signed [33:0] base;
    logic [30:0]        var_alt;
  } meta_t;

  // Restoring divider lane: partial remainder, numerator bits still to
  // shift in, divisor and quotient built so far.
  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] num;
    logic [31:0] den;
    logic [32:0] quo;
  } div_t;

  // Digit-by-digit square-root lane.
  typedef struct packed {
    logic [29:0] rem;
    logic [27:0] root;
    logic [55:0] x;
  } sq_t;

  function automatic logic [31:0] abs32(logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

  function automatic div_t div_step(div_t a);
    div_t        r;
    logic [32:0] sh;
    logic [32:0] diff;
    logic        ge;
    sh    = {a.rem, a.num[32]};
    ge    = sh >= {1'b0, a.den};
    diff  = sh - {1'b0, a.den};
    r.rem = ge ? diff[31:0] : sh[31:0];
    r.num = {a.num[31:0], 1'b0};
    r.den = a.den;
    r.quo = {a.quo[31:0], ge};
    return r;
  endfunction

  function automatic sq_t sqrt_step(sq_t a);
    sq_t         r;
    logic [31:0] sh;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;
    sh     = {a.rem, a.x[55:54]};
    trial  = {2'b00, a.root, 2'b01};
    ge     = sh >= trial;
    diff   = sh - trial;
    r.rem  = ge ? diff[29:0] : sh[29:0];
    r.root = {a.root[26:0], ge};
    r.x    = {a.x[53:0], 2'b00};
    return r;
  endfunction

endpackage

### rtl/core/mvs_div_cell.sv
// One cell of the divider chain: one quotient bit for both the mean and
// the variance division. Depends on mvs_pkg.
module mvs_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mvs_pkg::meta_t meta_i,
  input  mvs_pkg::div_t  mean_i,
  input  mvs_pkg::div_t  var_i,
  output logic           valid_o,
  output mvs_pkg::meta_t meta_o,
  output mvs_pkg::div_t  mean_o,
  output mvs_pkg::div_t  var_o
);
  import mvs_pkg::*;

  logic  valid_q;
  meta_t meta_q;
  div_t  mean_q;
  div_t  var_q;

  // Beat presence in this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Both lanes advance by one restoring step.
  always_ff @(posedge clk_i) begin
    meta_q <= meta_i;
    mean_q <= div_step(mean_i);
    var_q  <= div_step(var_i);
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign mean_o  = mean_q;
  assign var_o   = var_q;

endmodule

### rtl/core/mvs_sqrt_cell.sv
// One cell of the square-root chain: one root bit per cycle.
// Depends on mvs_pkg.
module mvs_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mvs_pkg::meta_t meta_i,
  input  mvs_pkg::sq_t   sq_i,
  output logic           valid_o,
  output mvs_pkg::meta_t meta_o,
  output mvs_pkg::sq_t   sq_o
);
  import mvs_pkg::*;

  logic  valid_q;
  meta_t meta_q;
  sq_t   sq_q;

  // Beat presence in this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Take two radicand bits and decide one root bit.
  always_ff @(posedge clk_i) begin
    meta_q <= meta_i;
    sq_q   <= sqrt_step(sq_i);
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign sq_o    = sq_q;

endmodule

### rtl/core/messenger_voxel_sampler_core.sv
// Top level of the messenger voxel sampler: input capture, products, a
// chain of divider cells, a chain of square-root cells and the noise add.
// Depends on mvs_pkg, mvs_div_cell and mvs_sqrt_cell.
//
// One voxel beat is taken in every cycle; busy stays low and the block
// never stalls. Each result passes through the 33 divider cells (one
// quotient bit each), the 28 square-root cells (one root bit each) and
// nine stages of multiply, add and saturation. Results are strobed for
// one cycle on sample_valid_o and cannot be held off, so the receiver
// must take every strobe. Register writes are always ready and are
// meant only while no voxel is in flight.
module messenger_voxel_sampler_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] noise_weight_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] signal_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] data_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] messenger_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] gaussian_draw_i,
  output logic                                sample_valid_o,
  output logic signed [mvs_pkg::VALUE_WIDTH-1:0] sample_value_o,
  output logic                                saturated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mvs_pkg::IDX_WIDTH-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);
  import mvs_pkg::*;

  // Configuration registers.
  logic                 mode_q;
  logic [TAU_WIDTH-1:0] tau_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      tau_q  <= 31'd16777216;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_MODE) begin
        mode_q <= cfg_data_i[0];
      end else if (cfg_index_i == REG_TAU) begin
        tau_q <= cfg_data_i[TAU_WIDTH-1:0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: classify the voxel and split values into sign and magnitude.
  logic        w_pos;
  logic        w_neg;
  meta_t       meta1_d;
  logic [30:0] wv1_d;

  always_comb begin
    w_pos            = !noise_weight_i[31] && (noise_weight_i != 32'sd0);
    w_neg            = noise_weight_i[31];
    wv1_d            = w_pos ? noise_weight_i[30:0] : 31'd0;
    meta1_d.mean_neg = 1'b0;
    meta1_d.draw_neg = gaussian_draw_i[31];
    meta1_d.draw_mag = abs32(gaussian_draw_i);
    meta1_d.base     = 34'sd0;
    meta1_d.var_alt  = 31'd0;
    if (mode_q) begin
      if (w_pos) begin
        meta1_d.kind = KIND_MEAN;
      end else if (w_neg) begin
        meta1_d.kind    = KIND_MASK;
        meta1_d.base    = 34'(signal_value_i);
        meta1_d.var_alt = tau_q;
      end else begin
        meta1_d.kind = KIND_PLAIN;
        meta1_d.base = 34'(data_value_i);
      end
    end else begin
      if (w_pos) begin
        meta1_d.kind    = KIND_MOCK;
        meta1_d.base    = 34'(messenger_value_i);
        meta1_d.var_alt = noise_weight_i[30:0];
      end else begin
        meta1_d.kind = KIND_PLAIN;
      end
    end
  end

  logic        valid1_q;
  meta_t       meta1_q;
  logic [30:0] wv1_q;
  logic [30:0] tau1_q;
  logic        s_neg1_q;
  logic [31:0] s_mag1_q;
  logic        d_neg1_q;
  logic [31:0] d_mag1_q;

  // Stage 2: the three products and the divisor.
  logic        valid2_q;
  meta_t       meta2_q;
  logic [62:0] ps2_q;
  logic [62:0] pd2_q;
  logic [61:0] pv2_q;
  logic [31:0] den2_q;
  logic        s_neg2_q;
  logic        d_neg2_q;

  // Stage 3: signed numerator of the mean.
  logic               valid3_q;
  meta_t              meta3_q;
  logic signed [64:0] sum3_d;
  logic signed [64:0] sum3_q;
  logic [61:0]        pv3_q;
  logic [31:0]        den3_q;

  always_comb begin
    sum3_d = (s_neg2_q ? -$signed({2'b00, ps2_q}) : $signed({2'b00, ps2_q}))
           + (d_neg2_q ? -$signed({2'b00, pd2_q}) : $signed({2'b00, pd2_q}));
  end

  // Stage 4: magnitudes with half the divisor added for rounding.
  logic        num_neg4;
  logic [63:0] num_mag4;
  logic [63:0] nm4;
  logic [63:0] nv4;
  meta_t       meta4_d;
  div_t        mean4_d;
  div_t        var4_d;

  always_comb begin
    num_neg4         = sum3_q[64];
    num_mag4         = num_neg4 ? 64'(-sum3_q) : sum3_q[63:0];
    nm4              = num_mag4 + 64'(den3_q >> 1);
    nv4              = 64'(pv3_q) + 64'(den3_q >> 1);
    meta4_d          = meta3_q;
    meta4_d.mean_neg = num_neg4;
    mean4_d.rem      = {1'b0, nm4[63:33]};
    mean4_d.num      = nm4[32:0];
    mean4_d.den      = den3_q;
    mean4_d.quo      = 33'd0;
    var4_d.rem       = {1'b0, nv4[63:33]};
    var4_d.num       = nv4[32:0];
    var4_d.den       = den3_q;
    var4_d.quo       = 33'd0;
  end

  // Divider chain taps; tap 0 is stage 4.
  logic  div_valid [DIV_STEPS+1];
  meta_t div_meta  [DIV_STEPS+1];
  div_t  div_mean  [DIV_STEPS+1];
  div_t  div_var   [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q     <= 1'b0;
      valid2_q     <= 1'b0;
      valid3_q     <= 1'b0;
      div_valid[0] <= 1'b0;
    end else begin
      valid1_q     <= accept;
      valid2_q     <= valid1_q;
      valid3_q     <= valid2_q;
      div_valid[0] <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    meta1_q     <= meta1_d;
    wv1_q       <= wv1_d;
    tau1_q      <= tau_q;
    s_neg1_q    <= signal_value_i[31];
    s_mag1_q    <= abs32(signal_value_i);
    d_neg1_q    <= data_value_i[31];
    d_mag1_q    <= abs32(data_value_i);
    meta2_q     <= meta1_q;
    ps2_q       <= 63'(s_mag1_q) * 63'(wv1_q);
    pd2_q       <= 63'(d_mag1_q) * 63'(tau1_q);
    pv2_q       <= 62'(wv1_q) * 62'(tau1_q);
    den2_q      <= 32'(wv1_q) + 32'(tau1_q);
    s_neg2_q    <= s_neg1_q;
    d_neg2_q    <= d_neg1_q;
    meta3_q     <= meta2_q;
    sum3_q      <= sum3_d;
    pv3_q       <= pv2_q;
    den3_q      <= den2_q;
    div_meta[0] <= meta4_d;
    div_mean[0] <= mean4_d;
    div_var[0]  <= var4_d;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    mvs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[i]),
      .meta_i  (div_meta[i]),
      .mean_i  (div_mean[i]),
      .var_i   (div_var[i]),
      .valid_o (div_valid[i+1]),
      .meta_o  (div_meta[i+1]),
      .mean_o  (div_mean[i+1]),
      .var_o   (div_var[i+1])
    );
  end

  // Stage 5: signed mean, variance pick and radicand.
  meta_t       meta5_d;
  logic [30:0] var5;
  sq_t         sq5_d;

  always_comb begin
    meta5_d = div_meta[DIV_STEPS];
    var5    = meta5_d.var_alt;
    if (meta5_d.kind == KIND_MEAN) begin
      meta5_d.base = meta5_d.mean_neg ? -$signed({1'b0, div_mean[DIV_STEPS].quo})
                                      : $signed({1'b0, div_mean[DIV_STEPS].quo});
      var5         = div_var[DIV_STEPS].quo[30:0];
    end
    sq5_d.rem  = 30'd0;
    sq5_d.root = 28'd0;
    sq5_d.x    = {1'b0, var5, {FRAC_BITS{1'b0}}};
  end

  // Square-root chain taps; tap 0 is stage 5.
  logic  sq_valid [SQRT_STEPS+1];
  meta_t sq_meta  [SQRT_STEPS+1];
  sq_t   sq_lane  [SQRT_STEPS+1];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    mvs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[j]),
      .meta_i  (sq_meta[j]),
      .sq_i    (sq_lane[j]),
      .valid_o (sq_valid[j+1]),
      .meta_o  (sq_meta[j+1]),
      .sq_o    (sq_lane[j+1])
    );
  end

  // Stages 6 to 9: rounded sigma, product, rounded noise, sum and clip.
  logic               valid6_q;
  meta_t              meta6_q;
  logic [28:0]        sigma6_q;
  logic               valid7_q;
  meta_t              meta7_q;
  logic [60:0]        prod7_q;
  logic               valid8_q;
  logic signed [39:0] base8_q;
  logic signed [39:0] noise8_d;
  logic signed [39:0] noise8_q;
  logic [60:0]        round8;
  logic               valid9_q;
  logic signed [39:0] res9;
  logic [31:0]        value9_d;
  logic               sat9_d;
  logic [31:0]        value9_q;
  logic               sat9_q;

  always_comb begin
    round8   = prod7_q + (61'd1 << (FRAC_BITS - 1));
    noise8_d = meta7_q.draw_neg ? -$signed(40'(round8[60:FRAC_BITS]))
                                : $signed(40'(round8[60:FRAC_BITS]));
  end

  always_comb begin
    res9 = base8_q + noise8_q;
    if (res9 > 40'sh007FFFFFFF) begin
      value9_d = 32'h7FFFFFFF;
      sat9_d   = 1'b1;
    end else if (res9 < 40'shFF80000000) begin
      value9_d = 32'h80000000;
      sat9_d   = 1'b1;
    end else begin
      value9_d = res9[31:0];
      sat9_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid[0] <= 1'b0;
      valid6_q    <= 1'b0;
      valid7_q    <= 1'b0;
      valid8_q    <= 1'b0;
      valid9_q    <= 1'b0;
    end else begin
      sq_valid[0] <= div_valid[DIV_STEPS];
      valid6_q    <= sq_valid[SQRT_STEPS];
      valid7_q    <= valid6_q;
      valid8_q    <= valid7_q;
      valid9_q    <= valid8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_meta[0] <= meta5_d;
    sq_lane[0] <= sq5_d;
    meta6_q    <= sq_meta[SQRT_STEPS];
    sigma6_q   <= 29'(sq_lane[SQRT_STEPS].root)
                + 29'(sq_lane[SQRT_STEPS].rem > 30'(sq_lane[SQRT_STEPS].root));
    meta7_q    <= meta6_q;
    prod7_q    <= 61'(sigma6_q) * 61'(meta6_q.draw_mag);
    base8_q    <= 40'(meta7_q.base);
    noise8_q   <= noise8_d;
    value9_q   <= value9_d;
    sat9_q     <= sat9_d;
  end

  assign sample_valid_o = valid9_q;
  assign sample_value_o = value9_q;
  assign saturated_o    = valid9_q && sat9_q;

endmodule

### rtl/core/mvs_checker.sv
// Port-level checks of the messenger voxel sampler over time, bound to the
// top level. Depends on mvs_pkg and messenger_voxel_sampler_core.
module mvs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic signed [mvs_pkg::VALUE_WIDTH-1:0] noise_weight_i,
  input logic signed [mvs_pkg::VALUE_WIDTH-1:0] data_value_i,
  input logic                                sample_valid_o,
  input logic signed [mvs_pkg::VALUE_WIDTH-1:0] sample_value_o,
  input logic                                saturated_o
);
  import mvs_pkg::*;

  // Every result strobe belongs to a beat taken a fixed latency earlier.
  a_strobe_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input beat");

  // A clipped result sits exactly on one end of the range.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> (sample_value_o == 32'sh7FFFFFFF ||
                     sample_value_o == 32'sh80000000))
    else $error("saturation flag with an unclipped value");

  // A zero weight yields the data value or zero, and no clipping.
  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_valid_o && $past(start && !busy && noise_weight_i == 32'sd0, LATENCY))
    |-> (!saturated_o && (sample_value_o == $past(data_value_i, LATENCY) ||
                          sample_value_o == 32'sd0)))
    else $error("zero-weight voxel gave an unexpected result");

endmodule

bind messenger_voxel_sampler_core mvs_checker u_mvs_checker (.*);

### verif/messenger_voxel_sampler_checker.sv
// Checker for the messenger voxel sampler: follows register writes, predicts each
// voxel's sample from the accepted beat and compares the strobed results in order.
// Depends on mvs_pkg for the sizes and register indexes.
`timescale 1ns / 100ps

module messenger_voxel_sampler_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] noise_weight_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] signal_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] data_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] messenger_value_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] gaussian_draw_i,
  input  logic                                   sample_valid_i,
  input  logic signed [mvs_pkg::VALUE_WIDTH-1:0] sample_value_i,
  input  logic                                   saturated_i,
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_ready_i,
  input  logic [mvs_pkg::IDX_WIDTH-1:0]          cfg_index_i,
  input  logic [31:0]                            cfg_data_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  import mvs_pkg::*;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          sat;
  } sample_t;

  sample_t                 sample_q[$];
  logic                    mode_q;
  logic [TAU_WIDTH-1:0]    tau_q;
  int                      errors;

  assign fail_count_o = errors;
  assign pending_o    = sample_q.size();

  // Square root of x rounded to the nearest integer.
  function automatic logic [127:0] root_nearest(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    if (x - r * r > r) r = r + 1;
    return r;
  endfunction

  // sigma * draw, with sigma the rounded root of the variance in fixed point.
  function automatic logic signed [127:0] noise_of(logic signed [127:0] variance,
                                                   logic signed [127:0] draw);
    logic [127:0] sigma;
    logic [127:0] mag;
    logic [127:0] amag;
    amag  = draw < 0 ? -draw : draw;
    sigma = root_nearest(variance << FRAC_BITS);
    mag   = (sigma * amag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return draw < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic sample_t predict_sample(logic signed [31:0] w_in, logic signed [31:0] s_in,
                                             logic signed [31:0] d_in, logic signed [31:0] m_in,
                                             logic signed [31:0] a_in);
    logic signed [127:0] w, s, d, m, a, t, den, num, nmag, mmag, mean, vv, res;
    sample_t             o;
    w = w_in; s = s_in; d = d_in; m = m_in; a = a_in;
    t = {97'd0, tau_q};
    res = 0;
    if (mode_q) begin
      if (w > 0) begin
        den  = w + t;
        num  = s * w + d * t;
        nmag = num < 0 ? -num : num;
        mmag = (nmag + (den >>> 1)) / den;
        mean = num < 0 ? -mmag : mmag;
        vv   = (w * t + (den >>> 1)) / den;
        res  = mean + noise_of(vv, a);
      end else if (w < 0) begin
        res = s + noise_of(t, a);
      end else begin
        res = d;
      end
    end else if (w > 0) begin
      res = m + noise_of(w, a);
    end
    // Clip to the signed value range.
    o.sat = 1'b0;
    if (res > 128'sh7FFF_FFFF) begin
      res = 128'sh7FFF_FFFF; o.sat = 1'b1;
    end else if (res < -128'sh8000_0000) begin
      res = -128'sh8000_0000; o.sat = 1'b1;
    end
    o.value = res[31:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
    errors++;
  endtask

  // Shadow registers, expected samples and the compare of each result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    sample_t e;
    if (!rst_ni) begin
      mode_q <= 1'b1;
      tau_q  <= 31'd16777216;
      errors = 0;
      sample_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MODE) mode_q <= cfg_data_i[0];
        else if (cfg_index_i == REG_TAU) tau_q <= cfg_data_i[TAU_WIDTH-1:0];
      end
      if (sample_valid_i) begin
        if (sample_q.size() == 0) begin
          report_mismatch("unexpected sample", sample_value_i, 0);
        end else begin
          e = sample_q.pop_front();
          if (sample_value_i !== e.value) report_mismatch("sample_value", sample_value_i, e.value);
          if (saturated_i !== e.sat) report_mismatch("saturated", saturated_i, e.sat);
        end
      end
      if (start_i && !busy_i)
        sample_q.push_back(predict_sample(noise_weight_i, signal_value_i, data_value_i,
                                          messenger_value_i, gaussian_draw_i));
    end
  end

endmodule

### verif/messenger_voxel_sampler_core_tb.sv
// Testbench top for the messenger voxel sampler: clock, reset, register phases and
// voxel stimulus with random gaps. Depends on mvs_pkg, the core and the checker.
`timescale 1ns / 100ps

module messenger_voxel_sampler_core_tb;
  import mvs_pkg::*;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] noise_weight_i, signal_value_i, data_value_i;
  logic signed [VALUE_WIDTH-1:0] messenger_value_i, gaussian_draw_i;
  logic                          sample_valid_o;
  logic signed [VALUE_WIDTH-1:0] sample_value_o;
  logic                          saturated_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [IDX_WIDTH-1:0]          cfg_index_i;
  logic [31:0]                   cfg_data_i;
  int                            fail_count;
  int                            pending;

  messenger_voxel_sampler_core u_top (.*);

  messenger_voxel_sampler_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .noise_weight_i, .signal_value_i, .data_value_i, .messenger_value_i, .gaussian_draw_i,
    .sample_valid_i(sample_valid_o), .sample_value_i(sample_value_o),
    .saturated_i(saturated_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Random value: extremes, small magnitudes up to about 2.0 or full range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(3);
      3, 4: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
      5, 6: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0: return 32'd0;
      1, 2: return 32'(-$signed({1'b0, $urandom_range(32'h0400_0000)}));
      3: return pick_value();
      default: return $urandom_range(32'h0800_0000, 1);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // One voxel beat; start stays high across back-to-back beats.
  task automatic send_voxel(logic [31:0] w, logic [31:0] s, logic [31:0] d,
                            logic [31:0] m, logic [31:0] a, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    noise_weight_i    <= w;
    signal_value_i    <= s;
    data_value_i      <= d;
    messenger_value_i <= m;
    gaussian_draw_i   <= a;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // One register write beat, then the write channel is left idle before the task returns.
  task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_directed();
    logic [31:0] one;
    one = 32'h0100_0000;
    send_voxel(one, one, -one, 0, one, 0);
    send_voxel(one, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0);
    send_voxel(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 32'h8000_0000, 0);
    send_voxel(32'h0000_0001, 32'h1234_5678, -32'h0ABC_DEF0, 32'hFFFF_FFFF, 0, 0);
    send_voxel(-one, one, 0, 0, -one, 1);
    send_voxel(32'h8000_0000, 32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0);
    send_voxel(0, $urandom, 32'h8000_0000, $urandom, $urandom, 0);
    send_voxel(0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 2);
    send_voxel(32'h0080_0000, -one, one, 0, 32'hFF80_0000, 0);
  endtask

  initial begin
    int gap;
    rst_ni            = 1'b0;
    start             = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    noise_weight_i    = '0;
    signal_value_i    = '0;
    data_value_i      = '0;
    messenger_value_i = '0;
    gaussian_draw_i   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset settings, then in mock mode and at tau limits.
    send_directed();
    wait_drained();
    write_reg(REG_MODE, 32'hFFFF_FFFE);
    send_directed();
    send_voxel(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    wait_drained();
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_TAU, 32'hFFFF_FFFF);
    write_reg(IDX_WIDTH'(5), 32'd0);
    send_directed();
    wait_drained();
    write_reg(REG_TAU, 32'd0);
    send_directed();
    wait_drained();

    // Random phases over several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin write_reg(REG_MODE, 1); write_reg(REG_TAU, 1); end
        1: write_reg(REG_MODE, 0);
        2: begin write_reg(REG_MODE, 1); write_reg(REG_TAU, 32'h7FFF_FFFF); end
        default: begin
          write_reg(REG_MODE, 1);
          write_reg(REG_TAU, $urandom_range(32'h0400_0000, 1));
        end
      endcase
      for (int i = 0; i < 112; i++) begin
        gap = ($urandom_range(7) == 0) ? 0 : pick_gap();
        send_voxel(pick_weight(), pick_value(), pick_value(), pick_value(), pick_value(),
                   (ph == 3) ? 0 : gap);
      end
      wait_drained();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
